// ----- hw/rtl/pwlc_pkg.sv -----
// Shared types and constants for the piecewise-linear calibration core.
// Holds the channel word layouts, the register indexes and the control states.
// No dependencies.
package pwlc_pkg;

    localparam int VALUE_W = 32;

    // Bits of the quotient kept ahead of clipping; any larger magnitude saturates.
    localparam int QUOT_W = 34;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic [7:0] CFG_POINT_COUNT = 8'd0;
    localparam logic [7:0] CFG_EXACT_MODE  = 8'd1;

    typedef struct packed {
        logic                      command;
        logic [3:0]                point_index;
        logic signed [VALUE_W-1:0] point_in;
        logic signed [VALUE_W-1:0] point_out;
        logic signed [VALUE_W-1:0] sample;
    } t_in_word;

    typedef struct packed {
        logic signed [VALUE_W-1:0] result_value;
        logic                      result_valid;
        logic                      saturated;
    } t_out_word;

    typedef struct packed {
        logic [7:0] index;
        logic [7:0] value;
    } t_cfg_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SEG,
        S_MUL,
        S_DCHK,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

endpackage

// ----- hw/rtl/pwlc_if.sv -----
// Valid/ready channel interfaces of the piecewise-linear calibration core.
// Depends on pwlc_pkg for the word layouts.
interface pwlc_in_if;
    import pwlc_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pwlc_out_if;
    import pwlc_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pwlc_cfg_if;
    import pwlc_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/pwlc_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module pwlc_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/piecewise_linear_calibration_core.sv -----
// Top level of the piecewise-linear calibration core.
// Depends on pwlc_pkg, the channel interfaces in pwlc_if and the RAM in pwlc_ram.
//
// Usage: words arrive on i_in. A load word (command 0) writes one breakpoint
// pair into the table and gives no result. An evaluate word (command 1) maps
// its sample to one result word on o_out. Registers point_count (index 0) and
// exact_mode (index 1) are written on i_cfg, which is always ready.
//
// Timing: a load is written into the table as it is accepted. An evaluate reads
// one table entry per cycle; exact mode and the single-point case then hand
// the result to the output register. Interpolation adds segment setup, a
// multiply, an overflow check, 34 divider steps (skipped on overflow) and a
// clip; a zero-width segment skips all but the setup. An empty table skips
// the scan. Only one evaluate is in flight; i_in.ready is high while the core is idle.
//
// Stalls: the result sits in an output register, so the core takes the next
// word while the previous result waits. A second result waits inside the core
// until the output register frees up, with i_in.ready low.
//
// Reset (synchronous, active low) clears the registers to zero, the control
// state and the output valid flag. The table has no reset; an entry must be
// loaded before an evaluate reads it.
module piecewise_linear_calibration_core #(
    parameter int MAX_POINTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pwlc_in_if.sink     i_in,
    pwlc_out_if.source  o_out,
    pwlc_cfg_if.sink    i_cfg
);

    import pwlc_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int EW = 2 * VALUE_W;

    // Configuration registers.
    logic [4:0] r_point_count;
    logic       r_exact_mode;

    // Control state.
    t_state r_state, n_state;

    // Scan pointer, read-data tracking and the first-segment flag.
    logic [CW-1:0] r_ra;
    logic          r_dv;
    logic [AW-1:0] r_di;
    logic          r_low;

    // Sample and the two segment end points.
    logic signed [VALUE_W-1:0] r_x;
    logic signed [VALUE_W-1:0] r_ia, r_oa, r_ib, r_ob;

    // Multiply and divide datapath.
    logic [VALUE_W-1:0]   r_mx, r_my, r_md;
    logic                 r_neg;
    logic [2*VALUE_W-1:0] r_prod;
    logic                 r_ovf;
    logic [VALUE_W-1:0]   r_rem;
    logic [QUOT_W-1:0]    r_dq;
    logic [5:0]           r_cnt;

    // Pending result and output register.
    t_out_word r_res;
    t_out_word r_out;
    logic      r_ov;

    // Table RAM: point input in the upper half, point output in the lower half.
    logic          ram_we;
    logic [AW-1:0] ram_wa;
    logic [EW-1:0] ram_wd;
    logic          ram_re;
    logic [EW-1:0] ram_rd;

    logic                      in_accept;
    logic [CW-1:0]             n_eff;
    logic signed [VALUE_W-1:0] e_in, e_out;
    logic                      last, hit, x_le, take, flat, out_free;

    logic signed [VALUE_W:0]   dx, dy, dd;
    logic [2*VALUE_W-1:0]      prod_w;
    logic                      ovf_w;
    logic [VALUE_W:0]          trial;
    logic                      ge;
    logic [QUOT_W-1:0]         qm;
    logic signed [QUOT_W+1:0]  sum;

    function automatic logic [VALUE_W-1:0] magnitude(input logic signed [VALUE_W:0] v);
        logic signed [VALUE_W:0] neg_v;
        neg_v = -v;
        return v[VALUE_W] ? neg_v[VALUE_W-1:0] : v[VALUE_W-1:0];
    endfunction

    pwlc_ram #(
        .WIDTH  (EW),
        .DEPTH  (MAX_POINTS),
        .ADDR_W (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wa),
        .i_wr_data (ram_wd),
        .i_rd_en   (ram_re),
        .i_rd_addr (r_ra[AW-1:0]),
        .o_rd_data (ram_rd)
    );

    // Channel handshakes. Configuration is taken at any time.
    assign i_in.ready  = (r_state == S_IDLE);
    assign in_accept   = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;
    assign out_free    = !r_ov || o_out.ready;

    // A point count beyond the table acts as a full table.
    assign n_eff = (32'(r_point_count) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(r_point_count);

    // Loads to a slot beyond the table are dropped.
    assign ram_we = in_accept && (i_in.data.command == CMD_LOAD)
                    && (32'(i_in.data.point_index) < MAX_POINTS);
    assign ram_wa = AW'(i_in.data.point_index);
    assign ram_wd = {i_in.data.point_in, i_in.data.point_out};
    assign ram_re = (r_state == S_SCAN) && (r_ra < n_eff);

    assign e_in  = ram_rd[EW-1:VALUE_W];
    assign e_out = ram_rd[VALUE_W-1:0];
    assign last  = (CW'(r_di) == (n_eff - CW'(1)));
    assign hit   = (e_in == r_x);
    assign x_le  = (r_x <= e_in);
    // The segment ends at this entry: first segment for a sample at or below the
    // first point, the first entry at or above the sample, or the last entry.
    assign take  = (r_di != AW'(0)) && (r_low || x_le || last);
    assign flat  = (r_ia == r_ib);

    // Segment differences, one bit wider than the points.
    assign dx = {r_x[VALUE_W-1], r_x} - {r_ia[VALUE_W-1], r_ia};
    assign dy = {r_ob[VALUE_W-1], r_ob} - {r_oa[VALUE_W-1], r_oa};
    assign dd = {r_ib[VALUE_W-1], r_ib} - {r_ia[VALUE_W-1], r_ia};

    assign prod_w = r_mx * r_my;
    // The quotient fits in QUOT_W bits exactly when the product is below the
    // divisor shifted up by QUOT_W.
    assign ovf_w  = {2'b00, r_prod} >= {r_md, {QUOT_W{1'b0}}};
    assign trial  = {r_rem, r_dq[QUOT_W-1]};
    assign ge     = trial >= {1'b0, r_md};
    assign qm     = r_ovf ? {1'b1, {(QUOT_W-1){1'b0}}} : r_dq;
    assign sum    = {{4{r_oa[VALUE_W-1]}}, r_oa}
                    + (r_neg ? -{2'b00, qm} : {2'b00, qm});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept && (i_in.data.command == CMD_EVAL)) begin
                    n_state = (n_eff == CW'(0)) ? S_OUT : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_dv) begin
                    if (r_exact_mode) begin
                        if (hit || last) begin
                            n_state = S_OUT;
                        end
                    end else if (n_eff == CW'(1)) begin
                        n_state = S_OUT;
                    end else if (take) begin
                        n_state = S_SEG;
                    end
                end
            end
            S_SEG:  n_state = flat ? S_OUT : S_MUL;
            S_MUL:  n_state = S_DCHK;
            S_DCHK: n_state = ovf_w ? S_FIN : S_DIV;
            S_DIV: begin
                if (r_cnt == 6'd0) begin
                    n_state = S_FIN;
                end
            end
            S_FIN:  n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Configuration registers and output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= 5'd0;
            r_exact_mode  <= 1'b0;
            r_ov          <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.data.index)
                    CFG_POINT_COUNT: r_point_count <= i_cfg.data.value[4:0];
                    CFG_EXACT_MODE:  r_exact_mode  <= i_cfg.data.value[0];
                    default: ;
                endcase
            end
            if ((r_state == S_OUT) && out_free) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && out_free) begin
            r_out <= r_res;
        end
        if (!i_rst_n) begin
            r_dv <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_x   <= i_in.data.sample;
                        r_ra  <= CW'(0);
                        r_dv  <= 1'b0;
                        r_low <= 1'b0;
                        r_res <= '{result_value: i_in.data.sample,
                                   result_valid: 1'b1, saturated: 1'b0};
                    end
                end
                S_SCAN: begin
                    if (ram_re) begin
                        r_ra <= r_ra + CW'(1);
                    end
                    r_dv <= ram_re;
                    r_di <= r_ra[AW-1:0];
                    if (r_dv) begin
                        if (r_exact_mode) begin
                            if (hit) begin
                                r_res <= '{result_value: e_out,
                                           result_valid: 1'b1, saturated: 1'b0};
                            end else if (last) begin
                                r_res <= '{result_value: '0,
                                           result_valid: 1'b0, saturated: 1'b0};
                            end
                        end else if (n_eff == CW'(1)) begin
                            r_res <= '{result_value: e_out,
                                       result_valid: 1'b1, saturated: 1'b0};
                        end else if (take) begin
                            r_ib <= e_in;
                            r_ob <= e_out;
                        end else begin
                            r_ia <= e_in;
                            r_oa <= e_out;
                            if (r_di == AW'(0)) begin
                                r_low <= x_le;
                            end
                        end
                    end
                end
                S_SEG: begin
                    // A zero-width segment returns the lower point only when it
                    // is the first segment taken for a sample at or below the first point.
                    r_res <= '{result_value: (r_low ? r_oa : r_ob),
                               result_valid: 1'b1, saturated: 1'b0};
                    r_mx  <= magnitude(dx);
                    r_my  <= magnitude(dy);
                    r_md  <= magnitude(dd);
                    r_neg <= dx[VALUE_W] ^ dy[VALUE_W] ^ dd[VALUE_W];
                end
                S_MUL: begin
                    r_prod <= prod_w;
                end
                S_DCHK: begin
                    r_ovf <= ovf_w;
                    r_rem <= VALUE_W'(r_prod[2*VALUE_W-1:QUOT_W]);
                    r_dq  <= r_prod[QUOT_W-1:0];
                    r_cnt <= 6'(QUOT_W - 1);
                end
                S_DIV: begin
                    // Dividend bits leave the top of r_dq as quotient bits enter
                    // at the bottom.
                    r_rem <= ge ? VALUE_W'(trial - {1'b0, r_md}) : trial[VALUE_W-1:0];
                    r_dq  <= {r_dq[QUOT_W-2:0], ge};
                    r_cnt <= r_cnt - 6'd1;
                end
                S_FIN: begin
                    if (sum[QUOT_W+1:VALUE_W-1] == '0
                        || sum[QUOT_W+1:VALUE_W-1] == '1) begin
                        r_res <= '{result_value: sum[VALUE_W-1:0],
                                   result_valid: 1'b1, saturated: 1'b0};
                    end else begin
                        r_res <= '{result_value: (sum[QUOT_W+1]
                                       ? {1'b1, {(VALUE_W-1){1'b0}}}
                                       : {1'b0, {(VALUE_W-1){1'b1}}}),
                                   result_valid: 1'b1, saturated: 1'b1};
                    end
                end
                S_OUT: ;
                default: ;
            endcase
        end
    end

    // The output register is only loaded from the result hand-off state.
    a_out_from_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == S_OUT))
        else $error("output word loaded outside the hand-off state");

    // Table data under inspection always comes from an entry in use.
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && r_dv |-> (CW'(r_di) < n_eff))
        else $error("scan read beyond the points in use");

    // The divider remainder stays below the divisor at every step.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_md))
        else $error("divider remainder not below divisor");

    // A clipped result always comes from a valid interpolation.
    a_sat_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (!r_out.saturated || r_out.result_valid))
        else $error("saturated flag on an invalid result");

endmodule
